### rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the alpha bounding box
// Coordinate and dimension widths, register indexes, and the structs that
// carry settings and results between the block's modules.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int COORD_W   = $clog2(MAX_DIM);      // 12: column / row position
	localparam int DIM_W     = COORD_W + 1;          // 13: dimension 1..MAX_DIM
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = DIM_W;
	localparam int ALPHA_W   = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA    = CFG_IDX_W'(2);

	localparam logic [DIM_W-1:0]   MAX_DIM_V   = DIM_W'(MAX_DIM);
	localparam logic [COORD_W-1:0] COORD_ONES  = '1;

	// Effective (clamped) frame settings.
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             has_alpha;
	} frame_cfg_t;

	// One bounding box result.
	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [DIM_W-1:0]   right;
		logic [DIM_W-1:0]   bottom;
		logic               found_any;
		logic               alpha_checked;
	} box_t;

	// Force a dimension into 1..MAX_DIM.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_DIM_V)
			r = MAX_DIM_V;
		else
			r = v;
		return r;
	endfunction

endpackage

### rtl/aabb_cfg.sv
// ----------------------------------------------------------------------------
// aabb_cfg: configuration registers
// Holds image width, image height and the alpha flag, and presents the
// clamped frame settings to the tracker.
// ----------------------------------------------------------------------------
module aabb_cfg import aabb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output frame_cfg_t           frame_cfg
);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             has_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_W'(1024);
			height_q    <= DIM_W'(1024);
			has_alpha_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q     <= cfg_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_data[DIM_W-1:0];
				REG_HAS_ALPHA:    has_alpha_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign frame_cfg.width     = clamp_dim(width_q);
	assign frame_cfg.height    = clamp_dim(height_q);
	assign frame_cfg.has_alpha = has_alpha_q;

endmodule

### rtl/aabb_tracker.sv
// ----------------------------------------------------------------------------
// aabb_tracker: raster position and running extent of opaque pixels
// Steps the column/row counters, folds each opaque pixel into the running
// min/max, and forms the frame result on the last pixel.
// ----------------------------------------------------------------------------
module aabb_tracker import aabb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [ALPHA_W-1:0] alpha,
	input  frame_cfg_t         frame_cfg,
	output logic               frame_end,
	output box_t               box
);

	logic [COORD_W-1:0] col_q, row_q;
	logic [COORD_W-1:0] min_col_q, min_row_q, max_col_q, max_row_q;
	logic               seen_q;

	logic               opaque;
	logic               row_end;
	logic [COORD_W-1:0] min_col_n, min_row_n, max_col_n, max_row_n;
	logic [DIM_W-1:0]   col_inc, row_inc;

	assign opaque  = (alpha != '0);
	assign col_inc = {1'b0, col_q} + DIM_W'(1);
	assign row_inc = {1'b0, row_q} + DIM_W'(1);
	assign row_end   = (col_inc >= frame_cfg.width);
	assign frame_end = row_end && (row_inc >= frame_cfg.height);

	// Fold the current pixel into the extent.
	always_comb begin
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		if (opaque) begin
			if (!seen_q || col_q < min_col_q) min_col_n = col_q;
			if (!seen_q || col_q > max_col_q) max_col_n = col_q;
			if (!seen_q || row_q < min_row_q) min_row_n = row_q;
			if (!seen_q || row_q > max_row_q) max_row_n = row_q;
		end
	end

	always_comb begin
		if (!frame_cfg.has_alpha || !(seen_q || opaque)) begin
			box.left      = '0;
			box.top       = '0;
			box.right     = frame_cfg.width;
			box.bottom    = frame_cfg.height;
			box.found_any = 1'b0;
		end else begin
			box.left      = min_col_n;
			box.top       = min_row_n;
			box.right     = {1'b0, max_col_n} + DIM_W'(1);
			box.bottom    = {1'b0, max_row_n} + DIM_W'(1);
			box.found_any = 1'b1;
		end
		box.alpha_checked = frame_cfg.has_alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= COORD_ONES;
			min_row_q <= COORD_ONES;
			max_col_q <= '0;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (step) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= COORD_ONES;
				min_row_q <= COORD_ONES;
				max_col_q <= '0;
				max_row_q <= '0;
				seen_q    <= 1'b0;
			end else begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_inc[COORD_W-1:0];
				end else begin
					col_q <= col_inc[COORD_W-1:0];
				end
				min_col_q <= min_col_n;
				min_row_q <= min_row_n;
				max_col_q <= max_col_n;
				max_row_q <= max_row_n;
				seen_q    <= seen_q | opaque;
			end
		end
	end

endmodule

### rtl/alpha_bounding_box.sv
// ----------------------------------------------------------------------------
// alpha_bounding_box: bounding box of the nonzero-alpha pixels of a frame
// Streams alpha bytes in raster order and reports one box per frame.
// ----------------------------------------------------------------------------
// Feed one alpha byte per request, top row first, each row left to right.
// The block accepts one pixel every cycle unless the input stalls; a request
// is registered on accept and folded into the running extent when it leaves
// the input register. The box of a frame is loaded into the output register
// at the same edge that folds its last pixel, and is then shown as valid.
// The input stalls only when the pixel in the input register ends a frame
// while the previous box is still waiting to be taken. Width and height are
// clamped to 1..4096 (zero reads as one); right and bottom are exclusive
// edges. A frame with no opaque pixel, or with has_alpha clear, reports the
// full image with found_any low; alpha_checked mirrors has_alpha at frame end.
// Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
module alpha_bounding_box import aabb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// pixel input
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ALPHA_W-1:0]   alpha,
	// box output
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [COORD_W-1:0]   box_left,
	output logic [COORD_W-1:0]   box_top,
	output logic [DIM_W-1:0]     box_right,
	output logic [DIM_W-1:0]     box_bottom,
	output logic                 found_any,
	output logic                 alpha_checked
);

	frame_cfg_t         frame_cfg;
	box_t               box;
	logic               frame_end;

	logic               valid_s1;
	logic [ALPHA_W-1:0] alpha_s1;
	logic               step;
	logic               out_free;
	logic               in_take;

	logic               out_valid_q;
	box_t               box_q;

	aabb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame_cfg (frame_cfg)
	);

	aabb_tracker u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.alpha     (alpha_s1),
		.frame_cfg (frame_cfg),
		.frame_end (frame_end),
		.box       (box)
	);

	// Output slot is free if empty or being drained this cycle.
	assign out_free = !out_valid_q || !out_stall;

	// Advance the held pixel unless it ends a frame and the box slot is full.
	assign step     = valid_s1 && (!frame_end || out_free);
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			alpha_s1 <= alpha;
		end
	end

	// Result register: load on frame end, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && frame_end) begin
			box_q <= box;
		end
	end

	assign out_valid     = out_valid_q;
	assign box_left      = box_q.left;
	assign box_top       = box_q.top;
	assign box_right     = box_q.right;
	assign box_bottom    = box_q.bottom;
	assign found_any     = box_q.found_any;
	assign alpha_checked = box_q.alpha_checked;

endmodule

### bench/tb_alpha_bounding_box.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_bounding_box: self-checking bench for the alpha bounding box
// Streams alpha bytes through the pixel channel and keeps its own running
// extent of every frame. Each box the block reports is compared field by
// field with the oldest predicted box. The directed tests cover the special
// frames. Random phases then change the geometry, sometimes mid-frame, while
// both channels may idle in bursts.
// ----------------------------------------------------------------------------
module tb_alpha_bounding_box import aabb_pkg::*; ();

	// Index 3 decodes to no register; writes to it must leave the block alone.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	// Cycles without any accepted request, taken box or register write before the run is declared hung.
	localparam int QUIET_LIMIT = 2000;

	// ------------------------------------------------------------------------
	// Clock, reset and block ports
	// ------------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [ALPHA_W-1:0]   alpha     = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COORD_W-1:0]   box_left;
	logic [COORD_W-1:0]   box_top;
	logic [DIM_W-1:0]     box_right;
	logic [DIM_W-1:0]     box_bottom;
	logic                 found_any;
	logic                 alpha_checked;

	always #5 clk = ~clk;

	alpha_bounding_box u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.alpha         (alpha),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.box_left      (box_left),
		.box_top       (box_top),
		.box_right     (box_right),
		.box_bottom    (box_bottom),
		.found_any     (found_any),
		.alpha_checked (alpha_checked)
	);

	// ------------------------------------------------------------------------
	// Extent tracker: the bench's own view of the frame in progress
	// ------------------------------------------------------------------------
	logic [DIM_W-1:0] cfg_width  = DIM_W'(1024);
	logic [DIM_W-1:0] cfg_height = DIM_W'(1024);
	logic             cfg_alpha  = 1'b1;

	int col_pos, row_pos;           // raster position of the next pixel
	int lo_col, lo_row, hi_col, hi_row;
	bit any_opaque;

	box_t pending_boxes[$];         // boxes owed by frames already closed

	int mismatches   = 0;
	int src_gap_pct  = 20;          // chance of a sender pause before a request
	int sink_idle_pct = 20;         // chance of a receiver stall burst

	// Dimension as the block sees it: zero reads as one, the top saturates.
	function automatic int eff_dim(input logic [DIM_W-1:0] v);
		int r;
		if (v == '0)
			r = 1;
		else if (v > MAX_DIM)
			r = MAX_DIM;
		else
			r = int'(v);
		return r;
	endfunction

	task automatic clear_extent();
		col_pos    = 0;
		row_pos    = 0;
		lo_col     = MAX_DIM - 1;
		lo_row     = MAX_DIM - 1;
		hi_col     = 0;
		hi_row     = 0;
		any_opaque = 1'b0;
	endtask

	// Fold one accepted pixel into the extent; close the frame on its last pixel.
	task automatic fold_pixel(input logic [ALPHA_W-1:0] a);
		int   w, h;
		bit   row_end, frame_end;
		box_t b;
		w = eff_dim(cfg_width);
		h = eff_dim(cfg_height);
		if (a != '0) begin
			if (!any_opaque || col_pos < lo_col) lo_col = col_pos;
			if (!any_opaque || col_pos > hi_col) hi_col = col_pos;
			if (!any_opaque || row_pos < lo_row) lo_row = row_pos;
			if (!any_opaque || row_pos > hi_row) hi_row = row_pos;
			any_opaque = 1'b1;
		end
		// Compare against the current geometry, so a shrink mid-frame wraps.
		row_end   = (col_pos + 1 >= w);
		frame_end = row_end && (row_pos + 1 >= h);
		if (!frame_end) begin
			if (row_end) begin
				col_pos = 0;
				row_pos++;
			end else begin
				col_pos++;
			end
		end else begin
			if (!cfg_alpha || !any_opaque) begin
				// Report the whole image.
				b.left      = '0;
				b.top       = '0;
				b.right     = DIM_W'(w);
				b.bottom    = DIM_W'(h);
				b.found_any = 1'b0;
			end else begin
				b.left      = COORD_W'(lo_col);
				b.top       = COORD_W'(lo_row);
				b.right     = DIM_W'(hi_col + 1);
				b.bottom    = DIM_W'(hi_row + 1);
				b.found_any = 1'b1;
			end
			b.alpha_checked = cfg_alpha;
			pending_boxes.push_back(b);
			clear_extent();
		end
	endtask

	// ------------------------------------------------------------------------
	// Drivers: everything changes on the falling edge
	// ------------------------------------------------------------------------

	// Write one register; mirror it into the tracker on the edge that takes it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_IMAGE_WIDTH: cfg_width = val;
			REG_IMAGE_HEIGHT: cfg_height = val;
			REG_HAS_ALPHA: cfg_alpha = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Send one pixel request. Valid stays high on return, so back-to-back
	// requests never drop it; a pause first lowers it for a random burst.
	task automatic send_pixel(input logic [ALPHA_W-1:0] a);
		if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15) - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		alpha    <= a;
		// Hold the request until the block takes it.
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		fold_pixel(a);
	endtask

	// Random opacity: any nonzero byte with a chance of opaque_pct percent, otherwise zero.
	function automatic logic [ALPHA_W-1:0] pick_alpha(input int opaque_pct);
		logic [ALPHA_W-1:0] r;
		if ($urandom_range(0, 99) < opaque_pct)
			r = ALPHA_W'($urandom_range(1, 255));
		else
			r = '0;
		return r;
	endfunction

	// Mostly tiny frames; now and then a zero or a wider dimension.
	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		logic [DIM_W-1:0] d;
		r = $urandom_range(0, 99);
		if (r < 8)
			d = '0;
		else if (r < 90)
			d = DIM_W'($urandom_range(1, 4));
		else
			d = DIM_W'($urandom_range(5, 20));
		return d;
	endfunction

	// Send n transparent pixels, except the ones at hot_a and hot_b (-1: none).
	task automatic send_sparse(input int n, input int hot_a, input int hot_b);
		for (int i = 0; i < n; i++)
			send_pixel((i == hot_a || i == hot_b) ? pick_alpha(100) : '0);
	endtask

	// Drop valid, wait for every owed box, then let the pipeline run dry.
	task automatic drain(input int tail);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_boxes.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver: stall in random bursts of clock cycles
	// ------------------------------------------------------------------------
	int sink_left = 0;

	always @(negedge clk) begin
		if (sink_left > 0) begin
			sink_left--;
		end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			out_stall <= 1'b1;
			sink_left = $urandom_range(1, 15) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_box();
		box_t want;
		if (pending_boxes.size() == 0) begin
			$error("box reported with no frame end pending");
			mismatches++;
		end else begin
			want = pending_boxes.pop_front();
			check_field("box_left", 32'(want.left), 32'(box_left));
			check_field("box_top", 32'(want.top), 32'(box_top));
			check_field("box_right", 32'(want.right), 32'(box_right));
			check_field("box_bottom", 32'(want.bottom), 32'(box_bottom));
			check_field("found_any", 32'(want.found_any), 32'(found_any));
			check_field("alpha_checked", 32'(want.alpha_checked),
				32'(alpha_checked));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_box();
	end

	// ------------------------------------------------------------------------
	// Watchdog: any accepted request, taken box or register write counts as progress
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** alpha_bounding_box: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Start a frame under the reset geometry, then shrink it: the column
	// counter is already past the new row end and has to wrap.
	task automatic test_mid_frame_resize();
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(2));
		write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(2));
		send_pixel(8'h00);
		send_pixel(8'h01);
		send_pixel(8'h00);
	endtask

	// Zero dimensions read as one: every pixel closes a frame of its own.
	task automatic test_single_pixel_frames();
		drain(6);
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, '0);
		send_pixel(8'h00);
		send_pixel(8'h01);
		send_pixel(8'h80);
		send_pixel(8'hFF);
		send_pixel(8'h7F);
	endtask

	// No alpha channel: opaque pixels are ignored in the report. Upper data
	// bits are set to show only bit 0 of the register matters.
	task automatic test_no_alpha();
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(2));
		write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(2));
		write_reg(REG_HAS_ALPHA, CFG_DAT_W'(13'h1FFE));
		send_pixel(8'h00);
		send_pixel(8'hC3);
		send_pixel(8'h3C);
		send_pixel(8'h00);
	endtask

	// Alpha examined, but nothing opaque: full image, found_any low.
	task automatic test_nothing_opaque();
		drain(6);
		write_reg(REG_HAS_ALPHA, CFG_DAT_W'(1));
		repeat (4) send_pixel(8'h00);
	endtask

	// Opaque pixels at two opposite corners of a 3x2 frame span the image.
	task automatic test_corners();
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(3));
		send_pixel(8'h00);
		send_pixel(8'h00);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		send_pixel(8'h00);
		send_pixel(8'h00);
	endtask

	// Oversized widths: an all-ones width saturates to MAX_DIM, and MAX_DIM
	// itself is kept, so the one-row frame cannot close early; shrinking the width
	// mid-frame then wraps the column counter and closes it.
	task automatic test_dimension_extremes();
		drain(6);
		src_gap_pct   = 2;
		sink_idle_pct = 10;
		write_reg(REG_IMAGE_WIDTH, '1);
		write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(1));
		write_reg(REG_UNUSED, '1);
		send_sparse(12, 3, 9);
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(MAX_DIM));
		send_sparse(4, 1, -1);
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(8));
		send_pixel(8'h00);
	endtask

	// Random phases: fresh geometry and idling each time, whole frames of
	// random content, and now and then a frame cut short before the next
	// register change.
	task automatic test_random_frames();
		int pixels, n, area, density;
		logic [CFG_DAT_W-1:0] ha_word;
		pixels = 0;
		while (pixels < 400) begin
			drain(6);
			case ($urandom_range(0, 2))
				0: src_gap_pct = 0;
				1: src_gap_pct = 10;
				default: src_gap_pct = 35;
			endcase
			case ($urandom_range(0, 2))
				0: sink_idle_pct = 0;
				1: sink_idle_pct = 10;
				default: sink_idle_pct = 35;
			endcase
			write_reg(REG_IMAGE_WIDTH, pick_dim());
			write_reg(REG_IMAGE_HEIGHT, pick_dim());
			ha_word    = CFG_DAT_W'($urandom);
			ha_word[0] = ($urandom_range(0, 99) < 80);
			write_reg(REG_HAS_ALPHA, ha_word);
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, CFG_DAT_W'($urandom));
			case ($urandom_range(0, 3))
				0: density = 0;
				1: density = 8;
				2: density = 30;
				default: density = 100;
			endcase
			area = eff_dim(cfg_width) * eff_dim(cfg_height);
			n    = $urandom_range(1, 3) * area;
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, area);
			repeat (n) send_pixel(pick_alpha(density));
			pixels += n;
		end
	endtask

	// Closing stretch with no idling on either side: back-to-back single-pixel frames, then 3x2 frames.
	task automatic test_streaming();
		drain(6);
		src_gap_pct   = 0;
		sink_idle_pct = 0;
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(1));
		write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(1));
		write_reg(REG_HAS_ALPHA, CFG_DAT_W'(1));
		repeat (20) send_pixel(pick_alpha(50));
		drain(6);
		write_reg(REG_IMAGE_WIDTH, CFG_DAT_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DAT_W'(2));
		repeat (18) send_pixel(pick_alpha(30));
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		clear_extent();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_mid_frame_resize();
		test_single_pixel_frames();
		test_no_alpha();
		test_nothing_opaque();
		test_corners();
		test_dimension_extremes();
		test_random_frames();
		test_streaming();

		drain(10);
		if (mismatches == 0 && pending_boxes.size() == 0)
			$display("** alpha_bounding_box: PASSED **");
		else
			$display("** alpha_bounding_box: FAILED **");
		$finish;
	end

endmodule
